>>> design/gbcr_pkg.sv
package gbcr_pkg;

    // Field widths fixed by the sensor format.
    localparam int unsigned RATE_W   = 16;
    localparam int unsigned SUM_W    = 24;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 16;

    // Reciprocal scaling for the offset average: the sum magnitude stays below
    // 2^(SUM_W-1) and the divisor below 2^8, so this shift keeps the product exact.
    localparam int unsigned RECIP_SH = SUM_W - 1 + 8;
    localparam int unsigned RECIP_W  = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_USE_STORED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z   = 3'd3;

    // What an accepted beat asks for.
    typedef enum logic {
        KIND_SAMPLE  = 1'b0,
        KIND_RESTART = 1'b1
    } t_kind;

    typedef logic signed [RATE_W-1:0] t_rate;

    // One classified item as it waits between front and back.
    typedef struct packed {
        t_kind kind;
        t_rate raw_x;
        t_rate raw_y;
        t_rate raw_z;
    } t_item;

    // Handshake between the queue and the back end.
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_head;

endpackage

>>> design/gyro_bias_calibrate_and_remove.sv
// Path: a beat accepted on the slave side is held in the queue and then in the
// output register before it is offered on the master side; each beat gives exactly one result beat.
// Throughput: one beat per cycle while the master side takes results, set by the
// back end and the two-entry queue between front and back.
// Reset: synchronous, active low; clears the queue and output, sets registers
// to their reset values and starts a calibration countdown.
module gyro_bias_calibrate_and_remove
    import gbcr_pkg::*;
#(
    parameter int unsigned CALIB_SAMPLES = 250
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // x_low_byte, x_high_byte, y_low_byte, y_high_byte, z_low_byte, z_high_byte
    input  logic [47:0]          s_axis_tdata,
    // action
    input  logic [0:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // rate_x, rate_y, rate_z
    output logic [47:0]          m_axis_tdata,
    // calibrating, calibration_done
    output logic [1:0]           m_axis_tuser,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    logic    q_ready;
    logic    push;
    logic    pop;
    t_item   item;
    t_q_head head;
    t_rate   rate_x;
    t_rate   rate_y;
    t_rate   rate_z;
    logic    calibrating;
    logic    done;

    assign o_cfg_ready = 1'b1;

    gbcr_front u_front (
        .i_valid   (s_axis_tvalid),
        .i_action  (s_axis_tuser[0]),
        .i_bytes   (s_axis_tdata),
        .i_q_ready (q_ready),
        .o_ready   (s_axis_tready),
        .o_push    (push),
        .o_item    (item)
    );

    gbcr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (item),
        .i_pop   (pop),
        .o_ready (q_ready),
        .o_head  (head)
    );

    gbcr_back #(
        .CALIB_SAMPLES (CALIB_SAMPLES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_head        (head),
        .o_pop         (pop),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_rate_x      (rate_x),
        .o_rate_y      (rate_y),
        .o_rate_z      (rate_z),
        .o_calibrating (calibrating),
        .o_done        (done)
    );

    assign m_axis_tdata = {rate_z, rate_y, rate_x};
    assign m_axis_tuser = {done, calibrating};

endmodule

>>> design/gbcr_front.sv
module gbcr_front
    import gbcr_pkg::*;
(
    input  logic        i_valid,
    input  logic        i_action,
    input  logic [47:0] i_bytes,
    input  logic        i_q_ready,
    output logic        o_ready,
    output logic        o_push,
    output t_item       o_item
);

    // A beat is taken whenever the queue has room.
    assign o_ready = i_q_ready;
    assign o_push  = i_valid && i_q_ready;

    // Classify the beat and assemble the three signed rates, low byte first.
    always_comb begin
        o_item.kind  = i_action ? KIND_RESTART : KIND_SAMPLE;
        o_item.raw_x = t_rate'({i_bytes[15:8],  i_bytes[7:0]});
        o_item.raw_y = t_rate'({i_bytes[31:24], i_bytes[23:16]});
        o_item.raw_z = t_rate'({i_bytes[47:40], i_bytes[39:32]});
    end

endmodule

>>> design/gbcr_queue.sv
module gbcr_queue
    import gbcr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_item   i_item,
    input  logic    i_pop,
    output logic    o_ready,
    output t_q_head o_head
);

    t_item       r_slot [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic [1:0]  n_count;

    assign o_ready      = (r_count != 2'd2);
    assign o_head.valid = (r_count != 2'd0);
    assign o_head.item  = r_slot[r_rd_ptr];

    // Occupancy follows pushes and pops in the same cycle.
    always_comb begin
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    // Pointer and count registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    // Entry storage, no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

>>> design/gbcr_back.sv
module gbcr_back
    import gbcr_pkg::*;
#(
    parameter int unsigned CALIB_SAMPLES = 250
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  t_q_head              i_head,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_rate                o_rate_x,
    output t_rate                o_rate_y,
    output t_rate                o_rate_z,
    output logic                 o_calibrating,
    output logic                 o_done
);

    localparam int unsigned CNT_W = $clog2(CALIB_SAMPLES + 1);
    localparam int unsigned DIV   = CALIB_SAMPLES - 1;
    localparam longint unsigned RECIP_L =
        ((64'd1 << RECIP_SH) + 64'(DIV) - 64'd1) / 64'(DIV);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_L[RECIP_W-1:0];
    localparam logic [CNT_W-1:0]   CNT_START = CNT_W'(CALIB_SAMPLES);
    localparam int unsigned PROD_W = SUM_W + RECIP_W;
    localparam int unsigned QUO_W  = RATE_W + 1;

    // Configuration registers, used at the next restart.
    logic  r_use_stored;
    t_rate r_stored [3];

    // Calibration state.
    logic [CNT_W-1:0]        r_left;
    logic signed [SUM_W-1:0] r_sum [3];
    t_rate                   r_offset [3];

    // Output register.
    logic  r_out_valid;
    t_rate r_out_rate [3];
    logic  r_out_cal;
    logic  r_out_done;

    t_rate                   raw [3];
    logic [SUM_W-1:0]        sum_mag [3];
    logic [PROD_W-1:0]       prod [3];
    logic [QUO_W-1:0]        quo_mag [3];
    t_rate                   avg [3];
    logic [CNT_W-1:0]        n_left;
    logic                    n_done;

    assign o_pop = i_head.valid && (!r_out_valid || i_ready);

    assign raw[0] = i_head.item.raw_x;
    assign raw[1] = i_head.item.raw_y;
    assign raw[2] = i_head.item.raw_z;

    // Average of each sum by reciprocal multiply, truncated toward zero.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sum_mag[k] = r_sum[k][SUM_W-1] ? (~r_sum[k] + SUM_W'(1)) : r_sum[k];
            prod[k]    = PROD_W'(sum_mag[k]) * PROD_W'(RECIP);
            quo_mag[k] = prod[k][RECIP_SH +: QUO_W];
            avg[k]     = r_sum[k][SUM_W-1] ? RATE_W'(~quo_mag[k] + QUO_W'(1))
                                           : RATE_W'(quo_mag[k]);
        end
    end

    // Countdown after this item and the done flag it reports.
    always_comb begin
        n_left = r_left;
        if (i_head.item.kind == KIND_RESTART) begin
            n_left = r_use_stored ? '0 : CNT_START;
        end else if (r_left != '0) begin
            n_left = r_left - CNT_W'(1);
        end
        n_done = (n_left == '0);
    end

    // Configuration writes; indexes past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_stored <= 1'b0;
            r_stored[0]  <= '0;
            r_stored[1]  <= '0;
            r_stored[2]  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_USE_STORED: r_use_stored <= i_cfg_data[0];
                CFG_OFFSET_X:   r_stored[0]  <= t_rate'(i_cfg_data);
                CFG_OFFSET_Y:   r_stored[1]  <= t_rate'(i_cfg_data);
                CFG_OFFSET_Z:   r_stored[2]  <= t_rate'(i_cfg_data);
                default:        r_use_stored <= r_use_stored;
            endcase
        end
    end

    // Calibration state update per popped item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= CNT_START;
            for (int k = 0; k < 3; k++) begin
                r_sum[k]    <= '0;
                r_offset[k] <= '0;
            end
        end else if (o_pop) begin
            r_left <= n_left;
            for (int k = 0; k < 3; k++) begin
                if (i_head.item.kind == KIND_RESTART) begin
                    r_sum[k]    <= '0;
                    r_offset[k] <= r_use_stored ? r_stored[k] : '0;
                end else if (r_left == CNT_W'(1)) begin
                    r_offset[k] <= avg[k];
                end else if (r_left != '0) begin
                    r_sum[k] <= r_sum[k] + SUM_W'(raw[k]);
                end
            end
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload: zero for a restart, raw while calibrating, else offset removed with wrap.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_done <= n_done;
            if (i_head.item.kind == KIND_RESTART) begin
                r_out_cal <= 1'b0;
                for (int k = 0; k < 3; k++) begin
                    r_out_rate[k] <= '0;
                end
            end else begin
                r_out_cal <= (r_left != '0);
                for (int k = 0; k < 3; k++) begin
                    r_out_rate[k] <= (r_left != '0) ? raw[k] : raw[k] - r_offset[k];
                end
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_rate_x      = r_out_rate[0];
    assign o_rate_y      = r_out_rate[1];
    assign o_rate_z      = r_out_rate[2];
    assign o_calibrating = r_out_cal;
    assign o_done        = r_out_done;

endmodule

>>> design/gbcr_checker.sv
module gbcr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // Back-pressure on the input only comes from a stalled output.
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no pending result");

    // A beat neither calibrating nor done is a restart result and carries zero rates.
    a_restart_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == 2'b00 |-> m_axis_tdata == 48'd0)
        else $error("restart result with nonzero rates");

    // Reset empties the output register.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind gyro_bias_calibrate_and_remove gbcr_checker u_gbcr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

>>> tb/tb_gyro_bias_calibrate_and_remove.sv
module tb_gyro_bias_calibrate_and_remove;
    timeunit 1ns;
    timeprecision 1ps;

    import gbcr_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int CAL_N       = 250;
    localparam int ITEM_TARGET = 1750;
    localparam int CYCLE_LIMIT = 500_000;

    // One expected result beat: three rates plus the two status flags.
    typedef struct packed {
        t_rate [2:0] rate;
        logic        calibrating;
        logic        done;
    } rate_result_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [47:0]          s_axis_tdata = '0;
    logic [0:0]           s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [47:0]          m_axis_tdata;
    logic [1:0]           m_axis_tuser;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;

    // Stimulus and scoreboard storage.
    t_item        pending_beats [$];
    rate_result_t expected_rates [$];
    t_item        next_beat;
    int           n_queued = 0;
    int           n_fail = 0;
    int           cycle_count = 0;
    int           tx_gap = 0;
    int           rx_stall = 0;
    bit           tx_burst = 1'b0;
    bit           rx_burst = 1'b0;
    string        rate_name [3] = '{"rate_x", "rate_y", "rate_z"};

    // Predictor copy of the calibration state and the register file.
    logic [7:0]              cal_left = 8'(CAL_N);
    logic signed [SUM_W-1:0] cal_sum [3] = '{default: '0};
    t_rate                   axis_bias [3] = '{default: '0};
    logic                    stored_sel = 1'b0;
    t_rate                   stored_bias [3] = '{default: '0};

    gyro_bias_calibrate_and_remove #(
        .CALIB_SAMPLES(CAL_N)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Wait length for one beat; now and then a side flips into a stretch with no idling.
    function automatic int draw_wait(inout bit burst);
        if ($urandom_range(0, 49) == 0) burst = !burst;
        return burst ? 0 : int'($urandom_range(0, 11));
    endfunction

    function automatic int rand_rate();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    // Stored offsets lean toward the extremes of the signed range, zero and minus one.
    function automatic logic [CFG_DAT_W-1:0] pick_offset();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return CFG_DAT_W'($urandom);
        endcase
    endfunction

    task automatic queue_sample(input int x, input int y, input int z);
        pending_beats.push_back('{KIND_SAMPLE, t_rate'(x), t_rate'(y), t_rate'(z)});
        n_queued++;
    endtask

    // The rate bytes of a restart beat carry junk that the block must ignore.
    task automatic queue_restart();
        pending_beats.push_back('{KIND_RESTART, t_rate'($urandom), t_rate'($urandom),
                                  t_rate'($urandom)});
        n_queued++;
    endtask

    // Work out the result of one accepted beat and update the calibration state.
    task automatic predict_rates(input logic [0:0] kind, input logic [47:0] data);
        rate_result_t want;
        t_rate        raw [3];
        want = '0;
        if (kind == KIND_RESTART) begin
            for (int k = 0; k < 3; k++) cal_sum[k] = '0;
            if (stored_sel) begin
                cal_left  = '0;
                axis_bias = stored_bias;
            end else begin
                cal_left  = 8'(CAL_N);
                axis_bias = '{default: '0};
            end
        end else begin
            for (int k = 0; k < 3; k++) raw[k] = data[16*k +: 16];
            if (cal_left != 0) begin
                // Countdown: sum all but the last sample, which closes the average.
                want.calibrating = 1'b1;
                for (int k = 0; k < 3; k++) begin
                    if (cal_left == 1)
                        axis_bias[k] = t_rate'(int'(cal_sum[k]) / (CAL_N - 1));
                    else
                        cal_sum[k] = cal_sum[k] + raw[k];
                    want.rate[k] = raw[k];
                end
                cal_left = cal_left - 1'b1;
            end else begin
                for (int k = 0; k < 3; k++) want.rate[k] = raw[k] - axis_bias[k];
            end
        end
        want.done = (cal_left == 0);
        expected_rates.push_back(want);
    endtask

    task automatic compare_field(input string name, input logic signed [RATE_W:0] want,
                                 input logic signed [RATE_W:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endtask

    // One register write; the predictor copy changes when the beat is taken.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] val);
        int hold;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_USE_STORED: stored_sel = val[0];
            CFG_OFFSET_X:   stored_bias[0] = val;
            CFG_OFFSET_Y:   stored_bias[1] = val;
            CFG_OFFSET_Z:   stored_bias[2] = val;
            default: ;
        endcase
        hold = $urandom_range(0, 3);
        if (hold > 0) begin
            i_cfg_valid <= 1'b0;
            repeat (hold) @(posedge i_clk);
        end
    endtask

    // Idle means every beat sent and answered, plus a wait for the pipeline to drain.
    task automatic wait_idle();
        while (pending_beats.size() != 0 || s_axis_tvalid || expected_rates.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Sender: present queued beats with random gaps and predict each one taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) predict_rates(s_axis_tuser, s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_gap > 0 || pending_beats.size() == 0) begin
                    if (tx_gap > 0) tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end else begin
                    next_beat = pending_beats.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= next_beat.kind;
                    s_axis_tdata  <= {next_beat.raw_z, next_beat.raw_y, next_beat.raw_x};
                    tx_gap = draw_wait(tx_burst);
                end
            end
        end
    end

    // Receiver: stall at random and check each result beat against the oldest expectation.
    always @(posedge i_clk) begin
        rate_result_t want;
        rate_result_t got;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]};
                if (expected_rates.size() == 0) begin
                    $error("result beat with no expectation waiting");
                    n_fail++;
                end else begin
                    want = expected_rates.pop_front();
                    for (int k = 0; k < 3; k++)
                        compare_field(rate_name[k], want.rate[k], got.rate[k]);
                    compare_field("calibrating", want.calibrating, got.calibrating);
                    compare_field("calibration_done", want.done, got.done);
                end
                rx_stall = draw_wait(rx_burst);
            end else if (rx_stall > 0) begin
                rx_stall--;
            end
            m_axis_tready <= (rx_stall == 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("gyro_bias_calibrate_and_remove verification failed");
            $finish;
        end
    end

    initial begin
        int bias [3];
        int spread;
        int break_at;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Power-up countdown: extreme rates and byte patterns pass through raw.
        queue_sample(0, 0, 0);
        queue_sample(32767, -32768, -1);
        queue_sample(-32768, 32767, 1);
        queue_sample('h00FF, 'hFF00, 'h5AA5);
        queue_sample('hFF00, 'h00FF, 'hA55A);
        queue_restart();
        queue_sample(123, -456, 789);
        wait_idle();

        // Stored offsets at the extremes for x and y; they must not apply before a restart.
        write_reg(CFG_USE_STORED, {15'($urandom), 1'b1});
        write_reg(CFG_OFFSET_X, 16'h8000);
        write_reg(CFG_OFFSET_Y, 16'h7FFF);
        write_reg(CFG_OFFSET_Z, 16'h0001);
        for (int i = int'(CFG_OFFSET_Z) + 1; i < 2 ** CFG_IDX_W; i++)
            write_reg(CFG_IDX_W'(i), CFG_DAT_W'($urandom));
        i_cfg_valid <= 1'b0;
        queue_sample(100, -100, 'h1234);
        queue_restart();
        // Subtraction that wraps in both directions.
        queue_sample(32767, -32768, 0);
        queue_sample(-32768, 32767, -32768);
        queue_sample(0, 0, 0);
        queue_restart();
        queue_restart();
        queue_sample(rand_rate(), rand_rate(), rand_rate());
        wait_idle();
        write_reg(CFG_USE_STORED, {15'($urandom), 1'b0});
        i_cfg_valid <= 1'b0;

        // Random phases: new settings, mostly a restart and a full countdown, then tracking.
        while (n_queued < ITEM_TARGET) begin
            wait_idle();
            if ($urandom_range(0, 1)) write_reg(CFG_USE_STORED,
                                               {15'($urandom), 1'($urandom_range(0, 2) == 0)});
            if ($urandom_range(0, 1)) write_reg(CFG_OFFSET_X, pick_offset());
            if ($urandom_range(0, 1)) write_reg(CFG_OFFSET_Y, pick_offset());
            if ($urandom_range(0, 1)) write_reg(CFG_OFFSET_Z, pick_offset());
            if ($urandom_range(0, 7) == 0)
                write_reg(CFG_IDX_W'($urandom_range(int'(CFG_OFFSET_Z) + 1, 2 ** CFG_IDX_W - 1)),
                          CFG_DAT_W'($urandom));
            i_cfg_valid <= 1'b0;

            if ($urandom_range(0, 3) != 0) begin
                queue_restart();
                if (!stored_sel) begin
                    // Steady bias plus noise; sometimes cut short by a restart.
                    for (int k = 0; k < 3; k++) begin
                        case ($urandom_range(0, 3))
                            0: bias[k] = $urandom_range(0, 1) ? 32767 : -32768;
                            1: bias[k] = int'($urandom_range(0, 8)) - 4;
                            default: bias[k] = rand_rate();
                        endcase
                    end
                    case ($urandom_range(0, 7))
                        0, 1: spread = 0;
                        2, 3, 4: spread = $urandom_range(1, 8);
                        7: spread = 32767;
                        default: spread = $urandom_range(100, 2000);
                    endcase
                    break_at = ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, CAL_N - 1))
                                                          : -1;
                    for (int i = 0; i < CAL_N; i++) begin
                        if (i == break_at) queue_restart();
                        queue_sample(bias[0] + int'($urandom_range(0, 2 * spread)) - spread,
                                     bias[1] + int'($urandom_range(0, 2 * spread)) - spread,
                                     bias[2] + int'($urandom_range(0, 2 * spread)) - spread);
                    end
                end
            end

            // Tracking samples over the full range with a stray restart now and then.
            repeat ($urandom_range(20, 80)) begin
                if ($urandom_range(0, 39) == 0)
                    queue_restart();
                else
                    queue_sample(rand_rate(), rand_rate(), rand_rate());
            end
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (n_fail == 0)
            $display("gyro_bias_calibrate_and_remove verification clean");
        else
            $display("gyro_bias_calibrate_and_remove verification failed");
        $finish;
    end

endmodule

>>> filelist.f
design/gbcr_pkg.sv
design/gbcr_front.sv
design/gbcr_queue.sv
design/gbcr_back.sv
design/gyro_bias_calibrate_and_remove.sv
design/gbcr_checker.sv
tb/tb_gyro_bias_calibrate_and_remove.sv
